FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/hm_pkg.sv
// ----------------------------------------------------------------------------
// Henon map package
// Word format, constants, register indexes and the control/status bundles.
// ----------------------------------------------------------------------------
package hm_pkg;

  localparam int MAX_KEEP  = 64;
  localparam int FRAC_BITS = 40;
  localparam int WORD_BITS = 64;
  localparam int KEEP_BITS = $clog2(MAX_KEEP + 1);
  localparam int TRANS_BITS = 20;
  localparam int LIMIT_BITS = 63;

  typedef logic [WORD_BITS-1:0] word_t;

  // Fixed-point 1.0.
  localparam word_t ONE_Q = word_t'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    REG_COEF_B    = 2'd0,
    REG_TRANSIENT = 2'd1,
    REG_KEEP      = 2'd2,
    REG_LIMIT     = 2'd3
  } cfg_reg_t;

  // Which product the shared multiplier forms.
  typedef enum logic [1:0] {
    MUL_AX = 2'd0,
    MUL_TX = 2'd1,
    MUL_BX = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     cap;
    logic     update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic esc;
  } dp_stat_t;

endpackage

FILE: src/hm_mul.sv
// ----------------------------------------------------------------------------
// Iterative fixed-point multiplier
// Signed 64x64 product built from four 32x32 partial products, one per cycle,
// then rescaled by the fraction width with an overflow flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hm_mul import hm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  go,
  input  word_t op_a,
  input  word_t op_b,
  output logic  done,
  output word_t result,
  output logic  ovf
);

  localparam int HALF = WORD_BITS / 2;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int HI_LSB = FRAC_BITS + WORD_BITS - 1;
  localparam logic [2:0] LAST_PP   = 3'd3;
  localparam logic [2:0] LAST_ACC  = 3'd4;
  localparam logic [2:0] STAGE_NEG = 3'd5;

  logic                  run;
  logic [2:0]            stage;
  word_t                 ma;
  word_t                 mb;
  logic                  neg;
  logic [WORD_BITS-1:0]  pp;
  logic [1:0]            pp_stage;
  logic [PROD_BITS-1:0]  acc;
  logic [PROD_BITS-1:0]  prod;
  logic [HALF-1:0]       a_half;
  logic [HALF-1:0]       b_half;
  logic [WORD_BITS-1:0]  pp_full;
  logic [PROD_BITS-1:0]  pp_ext;
  logic [PROD_BITS-HI_LSB-1:0] hi_bits;

  assign a_half  = stage[1] ? ma[WORD_BITS-1:HALF] : ma[HALF-1:0];
  assign b_half  = stage[0] ? mb[WORD_BITS-1:HALF] : mb[HALF-1:0];
  assign pp_full = a_half * b_half;

  always_comb begin
    case (pp_stage)
      2'd0:    pp_ext = {{WORD_BITS{1'b0}}, pp};
      2'd1:    pp_ext = {{HALF{1'b0}}, pp, {HALF{1'b0}}};
      2'd2:    pp_ext = {{HALF{1'b0}}, pp, {HALF{1'b0}}};
      default: pp_ext = {pp, {WORD_BITS{1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      stage <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        stage <= '0;
      end else if (run) begin
        stage <= stage + 3'd1;
        if (stage == STAGE_NEG) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ma  <= op_a[WORD_BITS-1] ? word_t'('0 - op_a) : op_a;
      mb  <= op_b[WORD_BITS-1] ? word_t'('0 - op_b) : op_b;
      neg <= op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
      acc <= '0;
    end else if (run) begin
      if (stage <= LAST_PP) begin
        pp       <= pp_full;
        pp_stage <= stage[1:0];
      end
      if (stage != 3'd0 && stage <= LAST_ACC) begin
        acc <= acc + pp_ext;
      end
      if (stage == STAGE_NEG) begin
        prod <= neg ? ('0 - acc) : acc;
      end
    end
  end

  assign hi_bits = prod[PROD_BITS-1:HI_LSB];
  assign result  = prod[FRAC_BITS +: WORD_BITS];
  assign ovf     = !((&hi_bits) || !(|hi_bits));

  `ASSERT_NEXT(a_mul_done_pulse, done, !done, "multiplier done lasted more than one cycle")
  `ASSERT_NEXT(a_mul_go_runs, go, run && stage == 3'd0, "multiplier did not start on go")

endmodule

FILE: src/hm_datapath.sv
// ----------------------------------------------------------------------------
// Henon map datapath
// Orbit state, shared multiplier and the update x' = 1 - a*x*x + y, y' = b*x
// with overflow and escape detection.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hm_datapath import hm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  word_t                 coef_b,
  input  logic [LIMIT_BITS-1:0] escape_limit,
  input  word_t                 coef_a,
  input  word_t                 x_start,
  input  word_t                 y_start,
  output word_t                 coef_echo,
  output word_t                 x_value,
  output logic                  escaped
);

  word_t a_reg;
  word_t x_reg;
  word_t y_reg;
  word_t t_reg;
  word_t ny_reg;
  word_t echo_reg;
  logic  iter_bad;
  logic  esc;

  word_t op_a;
  word_t op_b;
  logic  mul_done;
  word_t mul_res;
  logic  mul_ovf;

  word_t diff;
  word_t nx;
  word_t sub_chk;
  word_t add_chk;
  word_t mag;
  logic  step_bad;

  always_comb begin
    case (cmd.mul_sel)
      MUL_AX:  op_a = a_reg;
      MUL_TX:  op_a = t_reg;
      MUL_BX:  op_a = coef_b;
      default: op_a = a_reg;
    endcase
    op_b = x_reg;
  end

  hm_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .go     (cmd.mul_go),
    .op_a   (op_a),
    .op_b   (op_b),
    .done   (mul_done),
    .result (mul_res),
    .ovf    (mul_ovf)
  );

  // New x and its overflow and escape checks.
  assign diff    = ONE_Q - t_reg;
  assign sub_chk = (ONE_Q ^ t_reg) & (ONE_Q ^ diff);
  assign nx      = diff + y_reg;
  assign add_chk = (diff ^ nx) & (y_reg ^ nx);
  assign mag     = nx[WORD_BITS-1] ? word_t'('0 - nx) : nx;
  assign step_bad = iter_bad || sub_chk[WORD_BITS-1] || add_chk[WORD_BITS-1] ||
                    (mag > {1'b0, escape_limit});

  always_ff @(posedge clk) begin
    if (rst) begin
      esc      <= 1'b0;
      iter_bad <= 1'b0;
    end else begin
      if (cmd.load) begin
        esc <= 1'b0;
      end else if (cmd.update) begin
        esc <= step_bad;
      end
      if (cmd.mul_go && cmd.mul_sel == MUL_AX) begin
        iter_bad <= 1'b0;
      end else if (cmd.cap) begin
        iter_bad <= iter_bad | mul_ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_reg    <= coef_a;
      x_reg    <= x_start;
      y_reg    <= y_start;
      echo_reg <= coef_a;
    end else if (cmd.update) begin
      x_reg <= nx;
      y_reg <= ny_reg;
    end
    if (cmd.cap) begin
      if (cmd.mul_sel == MUL_BX) begin
        ny_reg <= mul_res;
      end else begin
        t_reg <= mul_res;
      end
    end
  end

  assign stat.mul_done = mul_done;
  assign stat.esc      = esc;
  assign coef_echo     = echo_reg;
  assign x_value       = esc ? '0 : x_reg;
  assign escaped       = esc;

  `ASSERT_NEXT(a_esc_sticky, esc && !cmd.load, esc, "escape flag cleared within a run")
  `ASSERT_IMPLY(a_cap_on_done, cmd.cap, mul_done, "product captured without a finished multiply")

endmodule

FILE: src/hm_ctrl.sv
// ----------------------------------------------------------------------------
// Henon map controller
// Sequences transient and kept iterations, the three products of each step
// and the emission of result words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hm_ctrl import hm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output logic                  valid,
  output logic                  last,
  input  logic [TRANS_BITS-1:0] transient_steps,
  input  logic [KEEP_BITS-1:0]  keep_count,
  output ctrl_cmd_t             cmd,
  input  dp_stat_t              stat
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CHECK   = 9'b000000010,
    S_AX_WAIT = 9'b000000100,
    S_TX_GO   = 9'b000001000,
    S_TX_WAIT = 9'b000010000,
    S_BX_GO   = 9'b000100000,
    S_BX_WAIT = 9'b001000000,
    S_UPDATE  = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [TRANS_BITS-1:0] trans_left;
  logic [TRANS_BITS-1:0] trans_left_next;
  logic [KEEP_BITS-1:0]  keep_left;
  logic [KEEP_BITS-1:0]  keep_left_next;
  logic [KEEP_BITS-1:0]  keep_sat;

  assign keep_sat = (keep_count > KEEP_BITS'(MAX_KEEP)) ? KEEP_BITS'(MAX_KEEP) : keep_count;

  always_comb begin
    state_next      = state;
    trans_left_next = trans_left;
    keep_left_next  = keep_left;
    cmd             = '0;
    cmd.mul_sel     = MUL_AX;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load        = 1'b1;
          trans_left_next = transient_steps;
          keep_left_next  = keep_sat;
          if (keep_sat != '0) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // An escaped orbit skips the rest of the transient and emits directly.
        if (stat.esc) begin
          trans_left_next = '0;
          state_next      = S_EMIT;
        end else begin
          cmd.mul_go = 1'b1;
          state_next = S_AX_WAIT;
        end
      end
      S_AX_WAIT: begin
        if (stat.mul_done) begin
          cmd.cap    = 1'b1;
          state_next = S_TX_GO;
        end
      end
      S_TX_GO: begin
        cmd.mul_sel = MUL_TX;
        cmd.mul_go  = 1'b1;
        state_next  = S_TX_WAIT;
      end
      S_TX_WAIT: begin
        cmd.mul_sel = MUL_TX;
        if (stat.mul_done) begin
          cmd.cap    = 1'b1;
          state_next = S_BX_GO;
        end
      end
      S_BX_GO: begin
        cmd.mul_sel = MUL_BX;
        cmd.mul_go  = 1'b1;
        state_next  = S_BX_WAIT;
      end
      S_BX_WAIT: begin
        cmd.mul_sel = MUL_BX;
        if (stat.mul_done) begin
          cmd.cap    = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (trans_left != '0) begin
          trans_left_next = trans_left - 1'b1;
          state_next      = S_CHECK;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        keep_left_next = keep_left - 1'b1;
        if (keep_left == KEEP_BITS'(1)) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_CHECK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      trans_left <= '0;
      keep_left  <= '0;
    end else begin
      state      <= state_next;
      trans_left <= trans_left_next;
      keep_left  <= keep_left_next;
    end
  end

  assign busy  = (state != S_IDLE);
  assign valid = (state == S_EMIT);
  assign last  = (state == S_EMIT) && (keep_left == KEEP_BITS'(1));

  `ASSERT_NEXT(a_word_gap, valid, !valid, "result words in back-to-back cycles")
  `ASSERT_NEXT(a_last_ends_run, valid && last, !busy, "run continued after its last word")
  `ASSERT_IMPLY(a_emit_count, valid, keep_left != '0, "word emitted with no count left")

endmodule

FILE: src/henon_map_orbit_generator.sv
// Each map step forms three 64x64 products in turn on the shared multiplier,
// which sets the pace of the block. The first word follows the transient steps
// and one more step; once escaped, the remaining words come without map steps.
// One item at a time: busy stays high until the last word. Reset restores the
// register defaults and returns the block to idle; words cannot be stalled.
// ----------------------------------------------------------------------------
// Henon map orbit generator
// Runs a fixed-point Henon orbit per start word and emits the kept iterates.
// ----------------------------------------------------------------------------
module henon_map_orbit_generator import hm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] coef_a,
  input  logic [63:0] x_start,
  input  logic [63:0] y_start,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        valid,
  output logic [63:0] coef_echo,
  output logic [63:0] x_value,
  output logic        escaped,
  output logic        last
);

  word_t                 coef_b;
  logic [TRANS_BITS-1:0] transient_steps;
  logic [KEEP_BITS-1:0]  keep_count;
  logic [LIMIT_BITS-1:0] escape_limit;
  ctrl_cmd_t             cmd;
  dp_stat_t              stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b          <= word_t'(64'd329853488333);
      transient_steps <= TRANS_BITS'(100);
      keep_count      <= KEEP_BITS'(MAX_KEEP);
      escape_limit    <= LIMIT_BITS'(64'd1099511627776000000);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COEF_B:    coef_b          <= cfg_data;
        REG_TRANSIENT: transient_steps <= cfg_data[TRANS_BITS-1:0];
        REG_KEEP:      keep_count      <= cfg_data[KEEP_BITS-1:0];
        REG_LIMIT:     escape_limit    <= cfg_data[LIMIT_BITS-1:0];
        default:       ;
      endcase
    end
  end

  hm_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .valid           (valid),
    .last            (last),
    .transient_steps (transient_steps),
    .keep_count      (keep_count),
    .cmd             (cmd),
    .stat            (stat)
  );

  hm_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .coef_b       (coef_b),
    .escape_limit (escape_limit),
    .coef_a       (coef_a),
    .x_start      (x_start),
    .y_start      (y_start),
    .coef_echo    (coef_echo),
    .x_value      (x_value),
    .escaped      (escaped)
  );

endmodule

FILE: test/henon_orbit_checker.sv
// ----------------------------------------------------------------------------
// Henon orbit checker
// Watches the register port, the start handshake and the result strobe of the
// orbit generator. It predicts every iterate word of each accepted orbit and
// compares the words that come out, in order and field by field.
// ----------------------------------------------------------------------------
module henon_orbit_checker import hm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] coef_a,
  input  logic [63:0] x_start,
  input  logic [63:0] y_start,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        valid,
  input  logic [63:0] coef_echo,
  input  logic [63:0] x_value,
  input  logic        escaped,
  input  logic        last,
  output int          mismatches,
  output int          pending,
  output int          words_checked,
  output int          escaped_words
);

  localparam logic [63:0] B_DEFAULT     = 64'd329853488333;
  localparam logic [62:0] LIMIT_DEFAULT = 63'd1099511627776000000;

  typedef struct packed {
    logic [63:0] coef;
    logic [63:0] x;
    logic        esc;
    logic        last;
  } iterate_t;

  iterate_t expected_iterates[$];
  iterate_t want;
  iterate_t got;

  // Shadow copy of the block's registers.
  logic [63:0]         b_q;
  logic [TRANS_BITS-1:0] trans_n;
  logic [6:0]          keep_n;
  logic [LIMIT_BITS-1:0] limit_q;

  int errs;
  int checked;
  int esc_seen;

  // Fixed-point product; bit 64 flags a result that does not fit a word.
  function automatic logic [64:0] q_mul(input logic [63:0] p, input logic [63:0] q);
    logic signed [127:0] prod;
    logic signed [127:0] sh;
    prod = $signed({{64{p[63]}}, p}) * $signed({{64{q[63]}}, q});
    sh = prod >>> FRAC_BITS;
    return {(sh[127:63] != {65{sh[63]}}), sh[63:0]};
  endfunction

  // Word sum or difference; bit 64 flags signed overflow.
  function automatic logic [64:0] q_sum(input logic [63:0] p, input logic [63:0] q,
                                        input logic subtract);
    logic [64:0] s;
    if (subtract) s = {p[63], p} - {q[63], q};
    else          s = {p[63], p} + {q[63], q};
    return {(s[64] != s[63]), s[63:0]};
  endfunction

  // Runs one orbit with the current settings and queues its kept iterates.
  task automatic predict_orbit(input logic [63:0] a, input logic [63:0] x0,
                               input logic [63:0] y0);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] nx;
    logic [63:0] t;
    logic [63:0] mag;
    logic [64:0] r;
    logic        esc;
    int unsigned keep;
    int unsigned total;
    x = x0;
    y = y0;
    esc = 1'b0;
    keep = (keep_n > MAX_KEEP) ? MAX_KEEP : keep_n;
    total = trans_n + keep;
    if (keep == 0) return;
    for (int unsigned k = 0; k < total; k++) begin
      // Once escaped the orbit is frozen; transient steps are skipped too.
      if (!esc) begin
        r = q_mul(a, x);
        esc |= r[64];
        r = q_mul(r[63:0], x);
        esc |= r[64];
        t = r[63:0];
        r = q_sum(ONE_Q, t, 1'b1);
        esc |= r[64];
        r = q_sum(r[63:0], y, 1'b0);
        esc |= r[64];
        nx = r[63:0];
        r = q_mul(b_q, x);
        esc |= r[64];
        mag = nx[63] ? (64'd0 - nx) : nx;
        if (mag > {1'b0, limit_q}) esc = 1'b1;
        x = nx;
        y = r[63:0];
      end
      if (k >= trans_n) begin
        expected_iterates.push_back('{coef: a, x: esc ? 64'd0 : x, esc: esc,
                                      last: (k + 1 == total)});
        if (esc) esc_seen++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      b_q     = B_DEFAULT;
      trans_n = 20'd100;
      keep_n  = 7'd64;
      limit_q = LIMIT_DEFAULT;
      expected_iterates.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_COEF_B:    b_q     = cfg_data;
          REG_TRANSIENT: trans_n = cfg_data[TRANS_BITS-1:0];
          REG_KEEP:      keep_n  = cfg_data[6:0];
          REG_LIMIT:     limit_q = cfg_data[LIMIT_BITS-1:0];
          default: ;
        endcase
      end
      if (start && !busy) predict_orbit(coef_a, x_start, y_start);
      if (valid) begin
        got = '{coef: coef_echo, x: x_value, esc: escaped, last: last};
        if (expected_iterates.size() == 0) begin
          if (errs < 10)
            $display("unexpected word: coef_echo=%h x_value=%h escaped=%b last=%b",
                     coef_echo, x_value, escaped, last);
          errs++;
        end else begin
          want = expected_iterates.pop_front();
          if (got !== want) begin
            if (errs < 10) begin
              $display("word %0d mismatch: expected coef_echo=%h x_value=%h escaped=%b last=%b",
                       checked, want.coef, want.x, want.esc, want.last);
              $display("  got coef_echo=%h x_value=%h escaped=%b last=%b",
                       got.coef, got.x, got.esc, got.last);
            end
            errs++;
          end
        end
        checked++;
      end
    end
    mismatches    <= errs;
    pending       <= expected_iterates.size();
    words_checked <= checked;
    escaped_words <= esc_seen;
  end

  initial begin
    errs = 0;
    checked = 0;
    esc_seen = 0;
  end

endmodule

FILE: test/henon_map_orbit_generator_tb.sv
// ----------------------------------------------------------------------------
// Henon map orbit generator testbench
// Drives directed corner orbits and then random register settings and start
// words, with random sender gaps, into the block. The orbit checker beside it
// predicts and compares every iterate word; this module gives the verdict.
// ----------------------------------------------------------------------------
module henon_map_orbit_generator_tb;
  import hm_pkg::*;

  localparam int QUIET_LIMIT     = 250000;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 35;

  localparam logic [63:0] Q_1P4     = 64'd1539316278886;
  localparam logic [63:0] Q_0P3     = 64'd329853488333;
  localparam logic [63:0] Q_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Q_LIM_DEF = 64'd1099511627776000000;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [63:0] coef_a = '0;
  logic [63:0] x_start = '0;
  logic [63:0] y_start = '0;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        busy;
  logic        valid;
  logic [63:0] coef_echo;
  logic [63:0] x_value;
  logic        escaped;
  logic        last;

  int mismatches;
  int pending;
  int words_checked;
  int escaped_words;

  int          orbits_started = 0;
  int          reg_writes = 0;
  int          quiet_cycles = 0;
  logic [19:0] cur_trans = 20'd100;

  henon_map_orbit_generator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coef_a(coef_a), .x_start(x_start), .y_start(y_start),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .valid(valid), .coef_echo(coef_echo), .x_value(x_value),
    .escaped(escaped), .last(last)
  );

  henon_orbit_checker u_orbit_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coef_a(coef_a), .x_start(x_start), .y_start(y_start),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .valid(valid), .coef_echo(coef_echo), .x_value(x_value),
    .escaped(escaped), .last(last),
    .mismatches(mismatches), .pending(pending),
    .words_checked(words_checked), .escaped_words(escaped_words)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The longest quiet stretch of a correct run follows the 1000-step transient:
  // two settling waits back to back; the limit leaves a margin of five.
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d words still pending",
                 quiet_cycles, pending);
        $display("[henon_map_orbit_generator] ERROR");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Uniform value below 2**bits.
  function automatic logic [63:0] q_frac(input int bits);
    return rand64() >> (64 - bits);
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_TRANSIENT) cur_trans = data[19:0];
    reg_writes++;
    @(posedge clk);
  endtask

  // Presents one start word and returns in the step it is taken, start still high.
  task automatic issue_orbit(input logic [63:0] a, input logic [63:0] x,
                             input logic [63:0] y);
    start   <= 1'b1;
    coef_a  <= a;
    x_start <= x;
    y_start <= y;
    do @(posedge clk); while (busy);
    orbits_started++;
  endtask

  task automatic rest(input int n, input bit to_idle);
    start <= 1'b0;
    if (to_idle) begin
      do @(posedge clk); while (busy);
    end
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Waits for every word and for the block to go idle, then leaves a quiet
  // stretch of about one orbit's transient before registers change.
  task automatic quiesce();
    drain();
    while (busy) @(posedge clk);
    repeat (25 * cur_trans + 60) @(posedge clk);
  endtask

  initial begin
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] y;
    int          r;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: the classic attractor, one orbit from the origin and one from (1/4, -1/8).
    issue_orbit(Q_1P4, 64'd0, 64'd0);
    issue_orbit(Q_1P4, ONE_Q >> 2, -(ONE_Q >> 3));
    quiesce();

    // No transient, three kept words; upper data bits are junk to be masked.
    write_reg(REG_TRANSIENT, 64'hFFFF_FFFF_FFF0_0000);
    write_reg(REG_KEEP, 64'hFFFF_FFFF_FFFF_FF83);
    write_reg(REG_COEF_B, Q_0P3);
    write_reg(REG_LIMIT, Q_LIM_DEF | Q_MIN);
    issue_orbit(Q_MAX, Q_MAX, Q_MAX);
    issue_orbit(Q_MIN, Q_MIN, Q_MIN);
    issue_orbit(64'd0, 64'd0, 64'd0);
    issue_orbit(64'd0, 64'd0, Q_MAX);
    issue_orbit(64'd0, 64'd0, Q_MIN);
    issue_orbit(Q_MIN, ONE_Q, 64'd0);
    issue_orbit(Q_MAX, 64'd0, 64'd0);
    issue_orbit(ONE_Q, ONE_Q, 64'd0);
    quiesce();

    // Keep count above the maximum saturates; a zero limit escapes any nonzero x.
    write_reg(REG_KEEP, 64'd100);
    write_reg(REG_LIMIT, 64'd0);
    issue_orbit(ONE_Q, ONE_Q, 64'd0);
    issue_orbit(Q_1P4, 64'd0, 64'd0);
    quiesce();

    // Keep count zero: starts are taken but no orbit runs and nothing is emitted.
    write_reg(REG_KEEP, 64'd0);
    write_reg(REG_TRANSIENT, 64'd3);
    issue_orbit(Q_1P4, 64'd0, 64'd0);
    issue_orbit(ONE_Q, ONE_Q >> 1, 64'd0);
    quiesce();

    // Most negative b: the b*x product overflows once |x| passes 1.0.
    write_reg(REG_KEEP, 64'd127);
    write_reg(REG_TRANSIENT, 64'd1);
    write_reg(REG_LIMIT, Q_MAX);
    write_reg(REG_COEF_B, Q_MIN);
    issue_orbit(64'd0, ONE_Q >> 1, 64'd0);
    issue_orbit(64'd0, ONE_Q << 1, 64'd0);
    quiesce();

    write_reg(REG_COEF_B, Q_MAX);
    write_reg(REG_KEEP, 64'd1);
    write_reg(REG_TRANSIENT, 64'd2);
    issue_orbit(Q_1P4, 64'd0, 64'd0);
    quiesce();

    // One long transient on the attractor.
    write_reg(REG_COEF_B, Q_0P3);
    write_reg(REG_LIMIT, Q_LIM_DEF);
    write_reg(REG_TRANSIENT, 64'd1000);
    write_reg(REG_KEEP, 64'd2);
    issue_orbit(Q_1P4, 64'd0, 64'd0);
    quiesce();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      quiesce();
      r = $urandom_range(0, 9);
      if (r < 6)      write_reg(REG_COEF_B, q_frac(40) - (ONE_Q >> 1));
      else if (r < 8) write_reg(REG_COEF_B, Q_0P3);
      else            write_reg(REG_COEF_B, rand64());
      r = $urandom_range(0, 9);
      if (r < 7)      write_reg(REG_TRANSIENT, {rand64()} & ~64'hF_FFFF
                                 | 64'($urandom_range(0, 10)));
      else if (r < 9) write_reg(REG_TRANSIENT, 64'($urandom_range(11, 40)));
      else            write_reg(REG_TRANSIENT, 64'd0);
      r = $urandom_range(0, 9);
      if (r < 6)      write_reg(REG_KEEP, {rand64()} & ~64'h7F | 64'($urandom_range(1, 16)));
      else if (r < 8) write_reg(REG_KEEP, 64'($urandom_range(17, 64)));
      else            write_reg(REG_KEEP, 64'($urandom_range(65, 127)));
      r = $urandom_range(0, 9);
      if (r < 5)      write_reg(REG_LIMIT, Q_LIM_DEF);
      else if (r < 8) write_reg(REG_LIMIT, ONE_Q + q_frac(40));
      else            write_reg(REG_LIMIT, rand64());

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 19);
        if (r < 14) begin
          // Start near the attractor so the orbit lives through many steps.
          a = ONE_Q + q_frac(38) + q_frac(37);
          x = q_frac(40) - (ONE_Q >> 1);
          y = q_frac(39) - (ONE_Q >> 2);
        end else if (r < 17) begin
          a = q_frac(44);
          x = q_frac(43) - (ONE_Q << 2);
          y = q_frac(43) - (ONE_Q << 2);
        end else begin
          a = rand64();
          x = rand64();
          y = rand64();
        end
        issue_orbit(a, x, y);
        if (ph == 2 && i == 15)
          drain();
        else if (ph != RAND_PHASES - 1 && $urandom_range(0, 3) == 0)
          rest($urandom_range(1, 11), 1'($urandom_range(0, 1)));
      end
    end

    quiesce();
    $display("Summary: %0d orbits started over %0d register writes, %0d words checked",
             orbits_started, reg_writes, words_checked);
    $display("Summary: %0d escaped words, %0d mismatches", escaped_words, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("[henon_map_orbit_generator] OK");
    else
      $display("[henon_map_orbit_generator] ERROR");
    $finish;
  end

endmodule
